// ----- src/sobel_edge_color_blend_core_assert.svh -----
// Assertion helpers
`ifndef SOBEL_EDGE_COLOR_BLEND_CORE_ASSERT_SVH
`define SOBEL_EDGE_COLOR_BLEND_CORE_ASSERT_SVH

// same-cycle implication
`define SBL_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SBL_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/sbl_pkg.sv -----
`timescale 1ns / 1ps
package sbl_pkg;

  localparam int MAX_WIDTH_DEF = 2048;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_IMAGE_WIDTH  = 3'd0;
  localparam cfg_idx_t REG_IMAGE_HEIGHT = 3'd1;
  localparam cfg_idx_t REG_EDGE_RED     = 3'd2;
  localparam cfg_idx_t REG_EDGE_GREEN   = 3'd3;
  localparam cfg_idx_t REG_EDGE_BLUE    = 3'd4;

  localparam logic [11:0] IMAGE_WIDTH_RST  = 12'd640;
  localparam logic [12:0] IMAGE_HEIGHT_RST = 13'd480;

  localparam logic [15:0] LUMA_R = 16'd77;
  localparam logic [15:0] LUMA_G = 16'd151;
  localparam logic [15:0] LUMA_B = 16'd28;

  // square root unit
  localparam int SQ_IN_W  = 21;
  localparam int SQ_OUT_W = 11;
  localparam int SQ_STEPS = 11;

  // blend
  localparam int          MIX_W       = 18;
  localparam logic [9:0]  BLEND_MAX   = 10'd1000;
  localparam int          RECIP_W     = 19;
  localparam logic [18:0] RECIP       = 19'd268436;
  localparam int          RECIP_SHIFT = 28;

  typedef struct packed {
    logic                done;
    logic [SQ_OUT_W-1:0] root;
  } sbl_sq_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SQUARE,
    ST_START,
    ST_ROOT,
    ST_MIX,
    ST_LOAD
  } sbl_state_t;

endpackage

// ----- src/sbl_if.sv -----
`timescale 1ns / 1ps
interface sbl_pixel_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  modport source (output valid, req_type, red_in, green_in, blue_in, input ready);
  modport sink (input valid, req_type, red_in, green_in, blue_in, output ready);
endinterface

interface sbl_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       row_end;
  logic       frame_end;
  modport source (output valid, red_out, green_out, blue_out, row_end, frame_end,
                  input ready);
  modport sink (input valid, red_out, green_out, blue_out, row_end, frame_end,
                output ready);
endinterface

interface sbl_cfg_if import sbl_pkg::*; ;
  logic                  valid;
  logic                  ready;
  cfg_idx_t              index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/sbl_ram.sv -----
`timescale 1ns / 1ps
module sbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/sbl_sqrt.sv -----
`timescale 1ns / 1ps
module sbl_sqrt import sbl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [SQ_IN_W-1:0] radicand,
  output sbl_sq_stat_t       stat
);

  logic [SQ_IN_W-1:0] rem;
  logic [SQ_IN_W-1:0] rt;
  logic [SQ_IN_W-1:0] bitv;
  logic [3:0]         cnt;
  logic               busy;
  logic               done;
  logic [SQ_IN_W:0]   trial;

  assign trial = {1'b0, rt} + {1'b0, bitv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 4'(SQ_STEPS);
      end else if (busy) begin
        cnt <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= radicand;
      rt   <= '0;
      bitv <= SQ_IN_W'(1) << (2 * (SQ_STEPS - 1));
    end else if (busy) begin
      if ({1'b0, rem} >= trial) begin
        rem <= rem - trial[SQ_IN_W-1:0];
        rt  <= (rt >> 1) + bitv;
      end else begin
        rt <= rt >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  assign stat.done = done;
  assign stat.root = rt[SQ_OUT_W-1:0];

endmodule

// ----- src/sobel_edge_color_blend_core.sv -----
`timescale 1ns / 1ps
// Sobel edge color blend. RGB pixels enter in raster order on the pixel channel
// (req_type 0), are turned to gray and kept with their color in two line memories
// of four rows each, one write and one read port apiece. The pixel width+1 places
// back is then blended toward the edge color by the Sobel magnitude (clamped to
// 1000) and leaves on the result channel. After the frame, width+1 flush
// transfers (req_type 1) drain the rest; a flush before the frame input is
// complete is taken and dropped. An item with no result leaves the core idle;
// one that yields a result holds off the next item through nine reads of the
// gray memory over its one read port and the eleven-step iterative square
// root, and while the previous result still waits in the output register. A
// width or height write restarts the frame; pixel transfers are held off while
// a configuration write is offered. The result is held in an output register,
// so the next item is taken while it waits.
`include "sobel_edge_color_blend_core_assert.svh"
module sobel_edge_color_blend_core import sbl_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input logic          clk,
  input logic          rst,
  sbl_pixel_if.sink    pixel,
  sbl_result_if.source result,
  sbl_cfg_if.sink      cfg
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int AW    = CW + 2;
  localparam int DEPTH = 4 * (2 ** CW);

  sbl_state_t state, state_next;

  logic [11:0] image_width;
  logic [12:0] image_height;
  logic [7:0]  edge_red, edge_green, edge_blue;
  logic [CW:0] w_eff;
  logic [12:0] h_eff;

  logic [CW-1:0] in_col, out_col;
  logic [13:0]   in_row;
  logic [12:0]   out_row;

  logic pix_xfer, cfg_xfer, out_xfer;
  logic in_done, take, wr, emit;
  logic in_last_col, out_last_col, out_last_row, fe_now;

  logic [1:0]    win_slot [3];
  logic [CW-1:0] win_col [3];
  logic          row_end_r, frame_end_r;

  logic [3:0]  rd_cnt;
  logic [1:0]  rd_ri, rd_ci;
  logic [3:0]  k;
  logic signed [11:0] gx, gy, gval;

  logic [15:0] luma;
  logic        gray_we;
  logic [AW-1:0] gray_raddr, color_raddr, waddr;
  logic [7:0]  gray_rdata;
  logic [23:0] color_rdata, color_r;

  logic [SQ_IN_W-1:0] mag2;
  logic               sq_start;
  sbl_sq_stat_t       sq_stat;
  logic [9:0]         weight;
  logic [MIX_W-1:0]   mix_r, mix_g, mix_b;
  logic [MIX_W+RECIP_W-1:0] prod_r, prod_g, prod_b;

  logic       out_valid;
  logic [7:0] out_red, out_green, out_blue;
  logic       out_row_end, out_frame_end;

  // effective frame size
  always_comb begin
    if (image_width == 12'd0) begin
      w_eff = (CW + 1)'(1);
    end else if (14'(image_width) > 14'(MAX_WIDTH)) begin
      w_eff = (CW + 1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW + 1)'(image_width);
    end
  end
  assign h_eff = (image_height == 13'd0) ? 13'd1 : image_height;

  assign pixel.ready = (state == ST_IDLE) && !cfg.valid;
  assign cfg.ready   = 1'b1;
  assign pix_xfer    = pixel.valid && pixel.ready;
  assign cfg_xfer    = cfg.valid && cfg.ready;
  assign out_xfer    = out_valid && result.ready;

  assign in_done      = in_row >= {1'b0, h_eff};
  assign take         = pix_xfer && !(!in_done && pixel.req_type);
  assign wr           = pix_xfer && !in_done && !pixel.req_type;
  assign emit         = take && (in_row >= 14'd2 || (in_row == 14'd1 && in_col != '0));
  assign in_last_col  = ({1'b0, in_col} + (CW + 1)'(1)) >= w_eff;
  assign out_last_col = ({1'b0, out_col} + (CW + 1)'(1)) == w_eff;
  assign out_last_row = out_row == (h_eff - 13'd1);
  assign fe_now       = out_last_col && out_last_row;

  // configuration and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
      edge_red     <= '0;
      edge_green   <= '0;
      edge_blue    <= '0;
      in_col       <= '0;
      in_row       <= '0;
      out_col      <= '0;
      out_row      <= '0;
    end else if (cfg_xfer) begin
      unique case (cfg.index)
        REG_IMAGE_WIDTH: begin
          image_width <= cfg.data[11:0];
          in_col <= '0;
          in_row <= '0;
          out_col <= '0;
          out_row <= '0;
        end
        REG_IMAGE_HEIGHT: begin
          image_height <= cfg.data;
          in_col <= '0;
          in_row <= '0;
          out_col <= '0;
          out_row <= '0;
        end
        REG_EDGE_RED:   edge_red <= cfg.data[7:0];
        REG_EDGE_GREEN: edge_green <= cfg.data[7:0];
        REG_EDGE_BLUE:  edge_blue <= cfg.data[7:0];
        default: ;
      endcase
    end else if (take) begin
      if (emit && fe_now) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        if (in_last_col) begin
          in_col <= '0;
          in_row <= in_row + 14'd1;
        end else begin
          in_col <= in_col + CW'(1);
        end
        if (emit) begin
          if (out_last_col) begin
            out_col <= '0;
            out_row <= out_row + 13'd1;
          end else begin
            out_col <= out_col + CW'(1);
          end
        end
      end
    end
  end

  // line memories
  assign luma = 16'(pixel.blue_in) * LUMA_B + 16'(pixel.red_in) * LUMA_R
              + 16'(pixel.green_in) * LUMA_G;
  assign gray_we     = wr;
  assign waddr       = {in_row[1:0], in_col};
  assign gray_raddr  = {win_slot[rd_ri], win_col[rd_ci]};
  assign color_raddr = {win_slot[1], win_col[1]};

  sbl_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_gray_ram (
    .clk   (clk),
    .we    (gray_we),
    .waddr (waddr),
    .wdata (luma[15:8]),
    .raddr (gray_raddr),
    .rdata (gray_rdata)
  );

  sbl_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_color_ram (
    .clk   (clk),
    .we    (wr),
    .waddr (waddr),
    .wdata ({pixel.red_in, pixel.green_in, pixel.blue_in}),
    .raddr (color_raddr),
    .rdata (color_rdata)
  );

  // FSM
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    sq_start   = 1'b0;
    unique case (state)
      ST_IDLE:   if (emit && !cfg_xfer) state_next = ST_READ;
      ST_READ:   if (rd_cnt == 4'd9) state_next = ST_SQUARE;
      ST_SQUARE: state_next = ST_START;
      ST_START: begin
        sq_start   = 1'b1;
        state_next = ST_ROOT;
      end
      ST_ROOT:   if (sq_stat.done) state_next = ST_MIX;
      ST_MIX:    state_next = ST_LOAD;
      ST_LOAD:   if (!out_valid || result.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  assign k    = rd_cnt - 4'd1;
  assign gval = signed'({4'b0, gray_rdata});

  // window read, gradient, blend
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && emit) begin
      win_slot[0] <= (out_row == 13'd0) ? 2'd0 : 2'(out_row - 13'd1);
      win_slot[1] <= out_row[1:0];
      win_slot[2] <= out_last_row ? out_row[1:0] : 2'(out_row + 13'd1);
      win_col[0]  <= (out_col == '0) ? '0 : out_col - CW'(1);
      win_col[1]  <= out_col;
      win_col[2]  <= out_last_col ? out_col : out_col + CW'(1);
      row_end_r   <= out_last_col;
      frame_end_r <= fe_now;
      rd_cnt      <= '0;
      rd_ri       <= '0;
      rd_ci       <= '0;
      gx          <= '0;
      gy          <= '0;
    end else if (state == ST_READ) begin
      rd_cnt <= rd_cnt + 4'd1;
      if (rd_ci == 2'd2) begin
        rd_ci <= '0;
        rd_ri <= rd_ri + 2'd1;
      end else begin
        rd_ci <= rd_ci + 2'd1;
      end
      if (rd_cnt == 4'd1) begin
        color_r <= color_rdata;
      end
      if (rd_cnt != 4'd0) begin
        case (k) inside
          4'd0, 4'd6: gx <= gx + gval;
          4'd2, 4'd8: gx <= gx - gval;
          4'd3:       gx <= gx + (gval <<< 1);
          4'd5:       gx <= gx - (gval <<< 1);
          default: ;
        endcase
        case (k) inside
          4'd0, 4'd2: gy <= gy + gval;
          4'd1:       gy <= gy + (gval <<< 1);
          4'd6, 4'd8: gy <= gy - gval;
          4'd7:       gy <= gy - (gval <<< 1);
          default: ;
        endcase
      end
    end
    if (state == ST_SQUARE) begin
      mag2 <= SQ_IN_W'(gx * gx) + SQ_IN_W'(gy * gy);
    end
    if (state == ST_ROOT && sq_stat.done) begin
      weight <= (sq_stat.root > 11'(BLEND_MAX)) ? BLEND_MAX : sq_stat.root[9:0];
    end
    if (state == ST_MIX) begin
      mix_r <= MIX_W'(edge_red) * MIX_W'(weight)
             + MIX_W'(color_r[23:16]) * MIX_W'(BLEND_MAX - weight);
      mix_g <= MIX_W'(edge_green) * MIX_W'(weight)
             + MIX_W'(color_r[15:8]) * MIX_W'(BLEND_MAX - weight);
      mix_b <= MIX_W'(edge_blue) * MIX_W'(weight)
             + MIX_W'(color_r[7:0]) * MIX_W'(BLEND_MAX - weight);
    end
  end

  sbl_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (mag2),
    .stat     (sq_stat)
  );

  // divide by 1000 through the reciprocal
  assign prod_r = (MIX_W + RECIP_W)'(mix_r) * (MIX_W + RECIP_W)'(RECIP);
  assign prod_g = (MIX_W + RECIP_W)'(mix_g) * (MIX_W + RECIP_W)'(RECIP);
  assign prod_b = (MIX_W + RECIP_W)'(mix_b) * (MIX_W + RECIP_W)'(RECIP);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_LOAD && (!out_valid || result.ready)) begin
      out_valid <= 1'b1;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOAD && (!out_valid || result.ready)) begin
      out_red       <= prod_r[RECIP_SHIFT +: 8];
      out_green     <= prod_g[RECIP_SHIFT +: 8];
      out_blue      <= prod_b[RECIP_SHIFT +: 8];
      out_row_end   <= row_end_r;
      out_frame_end <= frame_end_r;
    end
  end

  assign result.valid     = out_valid;
  assign result.red_out   = out_red;
  assign result.green_out = out_green;
  assign result.blue_out  = out_blue;
  assign result.row_end   = out_row_end;
  assign result.frame_end = out_frame_end;

  `SBL_ASSERT_NOW(a_no_write_busy, clk, rst, state != ST_IDLE, !gray_we, "write while busy")
  `SBL_ASSERT_NXT(a_frame_restart, clk, rst, emit && fe_now, in_row == '0 && out_row == '0, "no restart")
  `SBL_ASSERT_NOW(a_weight_cap, clk, rst, state == ST_MIX || state == ST_LOAD, weight <= BLEND_MAX, "weight")

endmodule

// ----- test/sobel_edge_color_blend_core_test.sv -----
`timescale 1ns / 1ps
module sobel_edge_color_blend_core_test;
  import sbl_pkg::*;

  localparam int LINE_MAX = 2048;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
    logic       frame_end;
  } blended_pixel_t;

  class blend_scoreboard;
    bit [11:0] width_reg;
    bit [12:0] height_reg;
    bit [7:0]  edge_r, edge_g, edge_b;
    bit [7:0]  gray_mem[4][LINE_MAX];
    bit [23:0] color_mem[4][LINE_MAX];
    int unsigned in_col, in_row, out_col, out_row;
    blended_pixel_t pending_q[$];
    int errors;

    function new();
      width_reg  = IMAGE_WIDTH_RST;
      height_reg = IMAGE_HEIGHT_RST;
      edge_r = 0;
      edge_g = 0;
      edge_b = 0;
      errors = 0;
      restart();
    endfunction

    function void restart();
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
    endfunction

    function int unsigned w_eff();
      if (width_reg == 0) return 1;
      if (width_reg > LINE_MAX) return LINE_MAX;
      return width_reg;
    endfunction

    function int unsigned h_eff();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_IMAGE_WIDTH: begin
          width_reg = data[11:0];
          restart();
        end
        REG_IMAGE_HEIGHT: begin
          height_reg = data[12:0];
          restart();
        end
        REG_EDGE_RED:   edge_r = data[7:0];
        REG_EDGE_GREEN: edge_g = data[7:0];
        REG_EDGE_BLUE:  edge_b = data[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned isqrt(int unsigned n);
      int unsigned root;
      int unsigned trial;
      root = 0;
      for (int b = 11; b >= 0; b--) begin
        trial = root | (1 << b);
        if (trial * trial <= n) root = trial;
      end
      return root;
    endfunction

    function int unsigned clamp_idx(int v, int unsigned lim);
      if (v < 0) return 0;
      if (v >= int'(lim)) return lim - 1;
      return v;
    endfunction

    function logic [7:0] mix(int unsigned e, int unsigned c, int unsigned w);
      return 8'((e * w + c * (1000 - w)) / 1000);
    endfunction

    function void predict_output(int unsigned we, int unsigned he);
      int g[3][3];
      int gx, gy;
      int unsigned w, rr;
      bit [23:0] c;
      blended_pixel_t p;
      for (int dy = 0; dy < 3; dy++) begin
        rr = clamp_idx(int'(out_row) + dy - 1, he) % 4;
        for (int dx = 0; dx < 3; dx++)
          g[dy][dx] = gray_mem[rr][clamp_idx(int'(out_col) + dx - 1, we)];
      end
      gx = (g[0][0] - g[0][2]) + 2 * (g[1][0] - g[1][2]) + (g[2][0] - g[2][2]);
      gy = (g[0][0] + 2 * g[0][1] + g[0][2]) - (g[2][0] + 2 * g[2][1] + g[2][2]);
      w = isqrt(gx * gx + gy * gy);
      if (w > 1000) w = 1000;
      c = color_mem[out_row % 4][out_col];
      p.red = mix(edge_r, c[23:16], w);
      p.green = mix(edge_g, c[15:8], w);
      p.blue = mix(edge_b, c[7:0], w);
      p.row_end = (out_col == we - 1);
      p.frame_end = p.row_end && (out_row == he - 1);
      pending_q.push_back(p);
      if (p.frame_end) restart();
      else if (out_col + 1 >= we) begin
        out_col = 0;
        out_row++;
      end else out_col++;
    endfunction

    // returns 0 when the transfer is dropped
    function bit note_input(bit flush, bit [7:0] r, bit [7:0] gr, bit [7:0] b);
      int unsigned we, he, pos;
      we = w_eff();
      he = h_eff();
      if (in_row < he) begin
        if (flush) return 0;
        gray_mem[in_row % 4][in_col] = 8'((b * 28 + 77 * r + gr * 151) / 256);
        color_mem[in_row % 4][in_col] = {r, gr, b};
      end
      pos = in_row * we + in_col;
      if (in_col + 1 >= we) begin
        in_col = 0;
        in_row++;
      end else in_col++;
      if (pos >= we + 1) predict_output(we, he);
      return 1;
    endfunction

    function void check_output(logic [7:0] r, logic [7:0] gr, logic [7:0] b,
                               logic re, logic fe);
      blended_pixel_t p;
      if (pending_q.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
        return;
      end
      p = pending_q.pop_front();
      if (r !== p.red) begin
        $error("red_out exp %0d got %0d", p.red, r);
        errors++;
      end
      if (gr !== p.green) begin
        $error("green_out exp %0d got %0d", p.green, gr);
        errors++;
      end
      if (b !== p.blue) begin
        $error("blue_out exp %0d got %0d", p.blue, b);
        errors++;
      end
      if (re !== p.row_end) begin
        $error("row_end exp %0d got %0d", p.row_end, re);
        errors++;
      end
      if (fe !== p.frame_end) begin
        $error("frame_end exp %0d got %0d", p.frame_end, fe);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  always #10 clk = ~clk;

  sbl_pixel_if  pix();
  sbl_result_if res();
  sbl_cfg_if    cfg();

  sobel_edge_color_blend_core u_dut (
    .clk(clk), .rst(rst), .pixel(pix), .result(res), .cfg(cfg)
  );

  blend_scoreboard sb = new();
  int  counted = 0;
  int  got = 0;
  bit  no_gaps = 0;

  task automatic send_pixel(bit flush, bit [7:0] r, bit [7:0] gr, bit [7:0] b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      pix.valid = 0;
      repeat (gap) @(negedge clk);
    end
    pix.valid = 1;
    pix.req_type = flush;
    pix.red_in = r;
    pix.green_in = gr;
    pix.blue_in = b;
    do @(posedge clk); while (!pix.ready);
    if (sb.note_input(flush, r, gr, b)) counted++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    pix.valid = 0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    @(negedge clk);
    repeat (64) @(negedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg.valid = 1;
    cfg.index = idx;
    cfg.data = data;
    do @(posedge clk); while (!cfg.ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg.valid = 0;
  endtask

  task automatic set_frame(int w, int h);
    write_cfg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_cfg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
  endtask

  task automatic set_edge(bit [7:0] r, bit [7:0] gr, bit [7:0] b);
    write_cfg(REG_EDGE_RED, CFG_DATA_W'(r));
    write_cfg(REG_EDGE_GREEN, CFG_DATA_W'(gr));
    write_cfg(REG_EDGE_BLUE, CFG_DATA_W'(b));
  endtask

  // style: 0 random, 1 black/white, 2 extremes per channel
  task automatic run_frame(int w, int h, int style, bit noisy);
    bit [7:0] r, gr, b;
    int stop;
    stop = (noisy && $urandom_range(0, 3) == 0) ? $urandom_range(0, w * h) : -1;
    for (int i = 0; i < w * h + w + 1; i++) begin
      if (i == stop) return;
      if (noisy && $urandom_range(0, 9) == 0)
        send_pixel($urandom_range(0, 1), 8'($urandom), 8'($urandom), 8'($urandom));
      case (style)
        1: begin
          r = $urandom_range(0, 1) ? 8'hff : 8'h00;
          gr = r;
          b = r;
        end
        2: begin
          r = $urandom_range(0, 1) ? 8'hff : 8'h00;
          gr = $urandom_range(0, 1) ? 8'hff : 8'h00;
          b = $urandom_range(0, 1) ? 8'hff : 8'h00;
        end
        default: begin
          r = 8'($urandom);
          gr = 8'($urandom);
          b = 8'($urandom);
        end
      endcase
      send_pixel(i >= w * h, r, gr, b);
    end
  endtask

  initial begin
    res.ready = 0;
    forever begin
      int stall;
      stall = no_gaps ? 0 : $urandom_range(0, 7);
      if (got == 150) stall = 400;
      if (stall > 0) begin
        res.ready = 0;
        repeat (stall) @(negedge clk);
      end
      res.ready = 1;
      do @(posedge clk); while (!res.valid);
      sb.check_output(res.red_out, res.green_out, res.blue_out, res.row_end,
                      res.frame_end);
      got++;
      @(negedge clk);
    end
  end

  initial begin
    #20ms;
    $display("** sobel_edge_color_blend_core: FAILED **");
    $finish;
  end

  initial begin
    pix.valid = 0;
    pix.req_type = 0;
    pix.red_in = 0;
    pix.green_in = 0;
    pix.blue_in = 0;
    cfg.valid = 0;
    cfg.index = REG_IMAGE_WIDTH;
    cfg.data = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // reset geometry: a flush before the frame is done is dropped
    send_pixel(1, 8'h00, 8'h00, 8'h00);
    send_pixel(0, 8'hff, 8'h00, 8'h7f);
    send_pixel(0, 8'h00, 8'hff, 8'h80);
    wait_idle();
    set_edge(8'hff, 8'hff, 8'hff);
    set_frame(0, 0);
    send_pixel(0, 8'hff, 8'hff, 8'hff);
    send_pixel(0, 8'h12, 8'h34, 8'h56);  // past frame end, acts as flush
    wait_idle();
    set_frame(3, 2);
    run_frame(3, 2, 1, 0);
    wait_idle();
    set_edge(8'h00, 8'hff, 8'h00);
    write_cfg(REG_EDGE_BLUE + 3'd1, 13'h1fff);
    write_cfg(REG_EDGE_BLUE + 3'd3, 13'h0aaa);
    run_frame(3, 2, 2, 0);
    wait_idle();
    // saturated width and height, then restart
    set_frame(13'h1fff, 13'h1fff);
    send_pixel(0, 8'h01, 8'h02, 8'h03);
    wait_idle();
    set_frame(1, 4);
    run_frame(1, 4, 0, 0);

    while (counted < 1050) begin
      int w, h;
      wait_idle();
      no_gaps = ($urandom_range(0, 4) == 0);
      w = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      set_frame(w, h);
      case ($urandom_range(0, 3))
        0: set_edge(8'h00, 8'h00, 8'h00);
        1: set_edge(8'hff, 8'hff, 8'hff);
        default: set_edge(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      run_frame(w, h, $urandom_range(0, 2), $urandom_range(0, 3) == 0);
    end
    no_gaps = 0;
    wait_idle();

    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("** sobel_edge_color_blend_core: PASSED **");
    else
      $display("** sobel_edge_color_blend_core: FAILED **");
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+src
src/sbl_pkg.sv
src/sbl_if.sv
src/sbl_ram.sv
src/sbl_sqrt.sv
src/sobel_edge_color_blend_core.sv
test/sobel_edge_color_blend_core_test.sv
